// ===== rtl/bba_pkg.sv =====
// shared types and constants of the bitmap block allocator
package bba_pkg;

   // map geometry
   localparam int NUM_BLOCKS    = 256;
   localparam int USABLE_BLOCKS = NUM_BLOCKS - 1;
   localparam int WORD_W        = 32;
   localparam int BIT_W         = $clog2(WORD_W);
   localparam int NUM_WORDS     = (USABLE_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int WADDR_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int CNT_W         = $clog2(NUM_BLOCKS);
   localparam int GBLK_W        = WADDR_W + BIT_W;

   // operation codes
   localparam logic [1:0] FUNC_ALLOCATE = 2'd0;
   localparam logic [1:0] FUNC_REQUEST  = 2'd1;
   localparam logic [1:0] FUNC_RELEASE  = 2'd2;

   // bits of the last word that lie beyond the usable blocks
   function automatic logic [WORD_W-1:0] last_pad_f();
      logic [WORD_W-1:0] pad;
      pad = '0;
      for (int b = 0; b < WORD_W; b++) begin
         if ((NUM_WORDS - 1) * WORD_W + b >= USABLE_BLOCKS) begin
            pad[b] = 1'b1;
         end
      end
      return pad;
   endfunction

   localparam logic [WORD_W-1:0]  LAST_PAD  = last_pad_f();
   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] block_index;
   } req_type;

   typedef struct packed {
      logic       success;
      logic [7:0] granted_index;
      logic [7:0] used_count;
      logic [7:0] free_count;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_MOD  = 2'b10
   } state_type;

endpackage

// ===== rtl/bitmap_block_allocator.sv =====
// bitmap free-block allocator: word memory, read-modify-write control and result register
//
// The free-block map lives in a small synchronous memory of 32-bit words, one bit per
// block (set = used). The accept cycle of a transaction issues the read of the one
// bitmap word it touches, and the modify state then modifies that word, writes it back
// and loads the result register; no new request is taken before that is done. The next
// request is taken while a finished result still waits on the rsp side; if the result
// register is still occupied when the write-back is due, the write-back waits for it.
// Allocate picks the word through a per-word full flag held in flip-flops and then the
// lowest clear bit in that word, so its cost is the same as request and release. After
// reset there is no clearing pass: a per-word valid flag marks words written since
// reset, and a word not yet written reads as all free.
module bitmap_block_allocator
   import bba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // bitmap memory and its registered read port
   logic [WORD_W-1:0] map_mem [NUM_WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   // per-word flags, cleared by reset
   logic [NUM_WORDS-1:0] word_valid_ff, word_valid_in;
   logic [NUM_WORDS-1:0] word_full_ff, word_full_in;

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] used_total_ff, used_total_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // transaction fields held from accept to write-back
   logic [1:0]         func_ff, func_in;
   logic [WADDR_W-1:0] addr_ff, addr_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic               in_range_ff, in_range_in;
   logic               nonzero_ff, nonzero_in;
   logic               none_free_ff, none_free_in;

   // accept side
   logic                 req_fire;
   logic [31:0]          idx_wide;
   logic [NUM_WORDS-1:0] nonfull;
   logic [NUM_WORDS-1:0] first_nonfull;
   logic [WADDR_W-1:0]   alloc_addr;

   // modify side
   logic               out_free;
   logic [WORD_W-1:0]  word;
   logic [WORD_W-1:0]  pad;
   logic [WORD_W-1:0]  occ;
   logic [WORD_W-1:0]  low_zero;
   logic [BIT_W-1:0]   alloc_bit;
   logic [WORD_W-1:0]  sel_mask;
   logic [WORD_W-1:0]  new_word;
   logic               ok;
   logic               mem_we;
   logic [GBLK_W-1:0]  granted_blk;
   logic [CNT_W-1:0]   free_total;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // pick the lowest word that still has a free block
   always_comb begin
      idx_wide      = 32'(req_data.block_index);
      nonfull       = ~word_full_ff;
      first_nonfull = nonfull & (~nonfull + NUM_WORDS'(1));
      alloc_addr    = '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
         alloc_addr = alloc_addr | (first_nonfull[i] ? WADDR_W'(i) : '0);
      end
   end

   // capture the transaction and choose the word to read
   always_comb begin
      func_in      = func_ff;
      addr_in      = addr_ff;
      bit_in       = bit_ff;
      in_range_in  = in_range_ff;
      nonzero_in   = nonzero_ff;
      none_free_in = none_free_ff;
      if (req_fire) begin
         func_in      = req_data.func;
         bit_in       = idx_wide[BIT_W-1:0];
         in_range_in  = (idx_wide < 32'(USABLE_BLOCKS));
         nonzero_in   = (req_data.block_index != 8'd0);
         none_free_in = ~|nonfull;
         if (req_data.func == FUNC_ALLOCATE) begin
            addr_in = alloc_addr;
         end else begin
            addr_in = WADDR_W'(idx_wide >> BIT_W);
         end
      end
   end

   // modify the word that was read
   always_comb begin
      word      = word_valid_ff[addr_ff] ? rd_data_ff : '0;
      pad       = (addr_ff == LAST_WORD) ? LAST_PAD : '0;
      occ       = word | pad;
      low_zero  = ~occ & (occ + WORD_W'(1));
      alloc_bit = '0;
      for (int b = 0; b < WORD_W; b++) begin
         alloc_bit = alloc_bit | (low_zero[b] ? BIT_W'(b) : '0);
      end
      sel_mask = WORD_W'(1) << bit_ff;

      ok       = 1'b0;
      new_word = word;
      case (func_ff)
         FUNC_ALLOCATE: begin
            ok       = !none_free_ff;
            new_word = word | low_zero;
         end
         FUNC_REQUEST: begin
            ok       = in_range_ff && nonzero_ff && !word[bit_ff];
            new_word = word | sel_mask;
         end
         FUNC_RELEASE: begin
            ok       = in_range_ff && word[bit_ff];
            new_word = word & ~sel_mask;
         end
         default: begin
            ok       = 1'b0;
            new_word = word;
         end
      endcase

      granted_blk = {addr_ff, alloc_bit};
      mem_we      = (state_ff == S_MOD) && out_free && ok;
   end

   // next state, counts and result
   always_comb begin
      state_in      = state_ff;
      used_total_in = used_total_ff;
      word_valid_in = word_valid_ff;
      word_full_in  = word_full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      free_total    = CNT_W'(USABLE_BLOCKS) - used_total_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (out_free) begin
               if (ok) begin
                  if (func_ff == FUNC_RELEASE) begin
                     used_total_in = used_total_ff - CNT_W'(1);
                  end else begin
                     used_total_in = used_total_ff + CNT_W'(1);
                  end
                  word_valid_in[addr_ff] = 1'b1;
                  word_full_in[addr_ff]  = &(new_word | pad);
               end
               free_total = CNT_W'(USABLE_BLOCKS) - used_total_in;
               rsp_valid_in = 1'b1;
               rsp_data_in.success = ok;
               rsp_data_in.granted_index =
                  (ok && func_ff == FUNC_ALLOCATE) ? 8'(granted_blk) : 8'd0;
               // counts saturate at the field width
               rsp_data_in.used_count =
                  (32'(used_total_in) > 32'd255) ? 8'hff : 8'(used_total_in);
               rsp_data_in.free_count =
                  (32'(free_total) > 32'd255) ? 8'hff : 8'(free_total);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // bitmap memory: one read on accept, a write-back only for a successful transaction
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= map_mem[addr_in];
      end
      if (mem_we) begin
         map_mem[addr_ff] <= new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_total_ff <= '0;
         word_valid_ff <= '0;
         word_full_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_total_ff <= used_total_in;
         word_valid_ff <= word_valid_in;
         word_full_ff  <= word_full_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      addr_ff      <= addr_in;
      bit_ff       <= bit_in;
      in_range_ff  <= in_range_in;
      nonzero_ff   <= nonzero_in;
      none_free_ff <= none_free_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // the used count never exceeds the usable blocks
   assert property (@(posedge clock) disable iff (reset)
      32'(used_total_ff) <= 32'(USABLE_BLOCKS))
      else $error("used count beyond usable blocks");

   // the count moves by at most one block per cycle
   assert property (@(posedge clock) disable iff (reset)
      (used_total_ff == $past(used_total_ff)) ||
      (used_total_ff == $past(used_total_ff) + CNT_W'(1)) ||
      (used_total_ff == $past(used_total_ff) - CNT_W'(1)))
      else $error("used count jumped");

   // an accepted transaction always goes to the modify step
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_MOD))
      else $error("accepted transaction not processed");

   // write-back only happens from the modify step with room for the result
   assert property (@(posedge clock) disable iff (reset)
      mem_we |=> rsp_valid_ff)
      else $error("write-back without a result");

   // a full flag is only set while the count shows used blocks
   assert property (@(posedge clock) disable iff (reset)
      (|word_full_ff) |-> (used_total_ff != '0))
      else $error("word marked full with empty map");

endmodule

// ===== sim/bitmap_block_allocator_tb.sv =====
// self-checking testbench of the bitmap block allocator: scoreboard class and top module
`timescale 1ns / 1ps

class allocation_scoreboard;
   bit               used_map [bba_pkg::USABLE_BLOCKS];
   int unsigned      used_total;
   bba_pkg::rsp_type expected_rsp_q [$];
   int               checked_count;
   int               error_count;

   function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      used_total    = 0;
      checked_count = 0;
      error_count   = 0;
   endfunction

   // applies one transaction to the shadow map and returns the response it must give
   function bba_pkg::rsp_type predict_allocation(bba_pkg::req_type r);
      bba_pkg::rsp_type res;
      int unsigned      idx;
      int unsigned      free_left;
      res = '0;
      idx = r.block_index;
      case (r.func)
         bba_pkg::FUNC_ALLOCATE: begin
            for (int i = 0; i < bba_pkg::USABLE_BLOCKS; i++) begin
               if (!used_map[i]) begin
                  used_map[i]       = 1'b1;
                  used_total++;
                  res.success       = 1'b1;
                  res.granted_index = 8'(i);
                  break;
               end
            end
         end
         bba_pkg::FUNC_REQUEST: begin
            if (idx != 0 && idx < bba_pkg::USABLE_BLOCKS && !used_map[idx]) begin
               used_map[idx] = 1'b1;
               used_total++;
               res.success   = 1'b1;
            end
         end
         bba_pkg::FUNC_RELEASE: begin
            if (idx < bba_pkg::USABLE_BLOCKS && used_map[idx]) begin
               used_map[idx] = 1'b0;
               used_total--;
               res.success   = 1'b1;
            end
         end
         default: ;
      endcase
      free_left      = bba_pkg::USABLE_BLOCKS - used_total;
      res.used_count = (used_total > 255) ? 8'd255 : 8'(used_total);
      res.free_count = (free_left > 255) ? 8'd255 : 8'(free_left);
      return res;
   endfunction

   function void note_request(bba_pkg::req_type r);
      expected_rsp_q.push_back(predict_allocation(r));
   endfunction

   task report_mismatch(string msg);
      $display("mismatch at response %0d: %s", checked_count, msg);
      error_count++;
   endtask

   task check_response(bba_pkg::rsp_type got);
      bba_pkg::rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         report_mismatch($sformatf("response with nothing pending (success %0d index %0d)",
                                   got.success, got.granted_index));
      end else begin
         want = expected_rsp_q.pop_front();
         if (got.success !== want.success)
            report_mismatch($sformatf("success got %0d want %0d", got.success, want.success));
         if (got.granted_index !== want.granted_index)
            report_mismatch($sformatf("granted_index got %0d want %0d",
                                      got.granted_index, want.granted_index));
         if (got.used_count !== want.used_count)
            report_mismatch($sformatf("used_count got %0d want %0d",
                                      got.used_count, want.used_count));
         if (got.free_count !== want.free_count)
            report_mismatch($sformatf("free_count got %0d want %0d",
                                      got.free_count, want.free_count));
      end
      checked_count++;
   endtask
endclass

module bitmap_block_allocator_tb;
   import bba_pkg::*;

   // the one operation code the block does not define
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 1600;
   // random part runs in phases of this many transactions: fill, mixed, drain, mixed
   localparam int         PHASE_LEN    = 320;
   // idling is switched off for the closing stretch
   localparam int         QUIET_ITEMS  = 200;
   localparam int         DRAIN_LIMIT  = 2000;

   localparam int PHASE_FILL  = 0;
   localparam int PHASE_DRAIN = 2;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // idling on either side starts only while this is set
   bit      idle_enable = 1'b1;
   int      rsp_stall_left = 0;

   allocation_scoreboard scoreboard = new();

   bitmap_block_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: ready drops in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left != 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: every handshake is sampled at the edge that completes it
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) scoreboard.note_request(req_data);
         if (rsp_valid && rsp_ready) scoreboard.check_response(rsp_data);
      end
   end

   // presents one transaction, possibly after a gap, and returns once it is accepted;
   // valid is left high so back-to-back transactions need no lowering
   task automatic send_request(input logic [1:0] func, input logic [7:0] block_index);
      req_type item;
      item.func        = func;
      item.block_index = block_index;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // block index biased toward the map edges: zero, the last usable block, out of range
   function automatic logic [7:0] pick_index();
      logic [7:0] edges [5] = '{8'd0, 8'd1, 8'd253, 8'd254, 8'd255};
      if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 4)];
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      int         phase_kind;
      int         roll;
      int         wait_cycles;
      logic [1:0] func;
      logic [7:0] idx;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, starting from an empty map
      send_request(FUNC_ALLOCATE, 8'd0);     // lowest free: block zero
      send_request(FUNC_ALLOCATE, 8'd255);   // index ignored by allocate
      send_request(FUNC_REQUEST,  8'd0);     // block zero may not be requested
      send_request(FUNC_REQUEST,  8'd255);   // just past the map
      send_request(FUNC_REQUEST,  8'd254);   // last usable block
      send_request(FUNC_REQUEST,  8'd254);   // already used
      send_request(FUNC_REQUEST,  8'd2);
      send_request(FUNC_ALLOCATE, 8'd0);     // skips the requested block two
      send_request(FUNC_RELEASE,  8'd255);   // out of range, ignored
      send_request(FUNC_RELEASE,  8'd0);     // block zero can be released
      send_request(FUNC_RELEASE,  8'd0);     // already free, ignored
      send_request(FUNC_UNUSED,   8'd255);   // unused code changes nothing
      send_request(FUNC_UNUSED,   8'd0);
      send_request(FUNC_ALLOCATE, 8'd0);     // block zero handed out again
      send_request(FUNC_RELEASE,  8'd254);
      send_request(FUNC_RELEASE,  8'd200);   // never used
      send_request(FUNC_RELEASE,  8'd1);
      send_request(FUNC_RELEASE,  8'd2);
      send_request(FUNC_RELEASE,  8'd3);
      send_request(FUNC_RELEASE,  8'd0);     // map empty again

      // random part: fill phases run the map full and keep allocating past that,
      // drain phases issue mostly releases, mixed phases take anything
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         phase_kind  = (n / PHASE_LEN) % 4;
         idle_enable <= (n < RANDOM_ITEMS - QUIET_ITEMS) && ((n / PHASE_LEN) % 3 != 2);
         roll        = $urandom_range(0, 99);
         idx         = pick_index();
         if (phase_kind == PHASE_FILL) begin
            if (roll < 92)      func = FUNC_ALLOCATE;
            else if (roll < 96) func = FUNC_REQUEST;
            else                func = FUNC_RELEASE;
         end else if (phase_kind == PHASE_DRAIN) begin
            if (roll < 85)      func = FUNC_RELEASE;
            else if (roll < 93) func = FUNC_ALLOCATE;
            else if (roll < 98) func = FUNC_REQUEST;
            else                func = FUNC_UNUSED;
         end else begin
            func = 2'($urandom_range(0, 3));
         end
         send_request(func, idx);
      end
      req_valid <= 1'b0;

      // wait for every pending response, then let the pipeline settle
      wait_cycles = 0;
      while (scoreboard.expected_rsp_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (scoreboard.expected_rsp_q.size() != 0)
         scoreboard.report_mismatch($sformatf("%0d responses never arrived",
                                              scoreboard.expected_rsp_q.size()));

      if (scoreboard.error_count == 0) begin
         $display("bitmap_block_allocator verification clean");
      end else begin
         $display("bitmap_block_allocator verification failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("bitmap_block_allocator verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bba_pkg.sv
rtl/bitmap_block_allocator.sv
sim/bitmap_block_allocator_tb.sv
